### hdl/bmhq_pkg.sv
// Package for the binary max-heap priority queue.
// Holds sizes, status codes, the controller state type and the command/status structs.
// Depends on nothing; every other file of the block imports it.
package bmhq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int WIDE_W      = COUNT_W + 1;
    localparam int STATUS_W    = 2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;        // latch a new request
        logic rd_parent;    // read the parent of the hole
        logic move_parent;  // move the parent down into the hole
        logic load_last;    // take the former last entry as the moving value
        logic rd_children;  // read both children of the hole
        logic move_child;   // move the larger child up into the hole
        logic wr_val;       // write the moving value into the hole
        logic capture;      // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic has_child;
        logic up_gt;        // moving value is greater than its parent
        logic dn_ge;        // moving value is not below the larger child
    } stat_t;

endpackage

### hdl/bmhq_if.sv
// Handshake channel interfaces of the heap queue: request and response.
// Depends on bmhq_pkg for field widths.
interface bmhq_req_if;
    import bmhq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bmhq_rsp_if;
    import bmhq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [STATUS_W-1:0]           status;
    logic signed [VALUE_WIDTH-1:0] popped_value;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic [COUNT_W-1:0]            entry_count;
    logic                          is_empty;

    modport source (output valid, output status, output popped_value, output top_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input popped_value, input top_value,
                    input entry_count, input is_empty, output ready);
endinterface

### hdl/bmhq_ctrl.sv
// Controller state machine of the heap queue: sequences sift up and sift down.
// Depends on bmhq_pkg; drives the datapath by cmd_t and reads stat_t back.
module bmhq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic            req_type,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bmhq_pkg::cmd_t  cmd,
    input  bmhq_pkg::stat_t stat
);
    import bmhq_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (req_type == REQ_PUSH && !stat.full)
                        state_next = S_UP_RD;
                    else if (req_type == REQ_POP && !stat.empty)
                        state_next = S_DN_LOAD;
                    else
                        state_next = S_FINISH;
                end
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_gt)
                begin
                    cmd.move_parent = 1'b1;
                    state_next      = S_UP_RD;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DN_LOAD:
            begin
                cmd.load_last = 1'b1;
                state_next    = stat.empty ? S_FINISH : S_DN_RD;
            end
            S_DN_RD:
            begin
                if (stat.has_child)
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_ge)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.move_child = 1'b1;
                    state_next     = S_DN_RD;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || rsp_ready))
        else $error("result register overwritten while pending");

    // An accepted push that is not dropped always enters sift up.
    a_push_sifts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && req_type == REQ_PUSH && !stat.full) |=> (state_reg == S_UP_RD))
        else $error("accepted push did not start sift up");

    // At most one memory write per cycle.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_val, cmd.move_parent, cmd.move_child}))
        else $error("more than one heap write in a cycle");

endmodule

### hdl/bmhq_dp.sv
// Datapath of the heap queue: heap memory, moving value, hole position, count, result.
// Depends on bmhq_pkg; controlled by bmhq_ctrl through cmd_t and stat_t.
module bmhq_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bmhq_pkg::cmd_t                          cmd,
    output bmhq_pkg::stat_t                         stat,
    input  logic                                    req_type,
    input  logic signed [bmhq_pkg::VALUE_WIDTH-1:0] value,
    output logic [bmhq_pkg::STATUS_W-1:0]           status,
    output logic signed [bmhq_pkg::VALUE_WIDTH-1:0] popped_value,
    output logic signed [bmhq_pkg::VALUE_WIDTH-1:0] top_value,
    output logic [bmhq_pkg::COUNT_W-1:0]            entry_count,
    output logic                                    is_empty
);
    import bmhq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] heap_mem [CAPACITY];

    logic [COUNT_W-1:0]            count_reg;
    logic [ADDR_W-1:0]             pos_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic signed [VALUE_WIDTH-1:0] top_reg;
    logic signed [VALUE_WIDTH-1:0] popped_reg;
    logic [STATUS_W-1:0]           stat_reg;
    logic signed [VALUE_WIDTH-1:0] rd0_reg;
    logic signed [VALUE_WIDTH-1:0] rd1_reg;

    logic [STATUS_W-1:0]           res_status_reg;
    logic signed [VALUE_WIDTH-1:0] res_popped_reg;
    logic signed [VALUE_WIDTH-1:0] res_top_reg;
    logic [COUNT_W-1:0]            res_count_reg;

    logic [ADDR_W-1:0]             parent_idx;
    logic [ADDR_W-1:0]             last_idx;
    logic [WIDE_W-1:0]             lc_wide;
    logic [WIDE_W-1:0]             rc_wide;
    logic [WIDE_W-1:0]             cnt_wide;
    logic                          has_right;
    logic                          take_right;
    logic [ADDR_W-1:0]             best_idx;
    logic signed [VALUE_WIDTH-1:0] best_val;
    logic [ADDR_W-1:0]             rd0_addr;
    logic                          we;
    logic signed [VALUE_WIDTH-1:0] wdata;

    assign parent_idx = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign last_idx   = ADDR_W'(count_reg - COUNT_W'(1));
    assign lc_wide    = WIDE_W'({pos_reg, 1'b1});
    assign rc_wide    = lc_wide + WIDE_W'(1);
    assign cnt_wide   = WIDE_W'(count_reg);
    assign has_right  = rc_wide < cnt_wide;
    assign take_right = has_right && (rd1_reg > rd0_reg);
    assign best_idx   = take_right ? rc_wide[ADDR_W-1:0] : lc_wide[ADDR_W-1:0];
    assign best_val   = take_right ? rd1_reg : rd0_reg;

    always_comb
    begin
        stat.full      = (count_reg == COUNT_W'(CAPACITY));
        stat.empty     = (count_reg == '0);
        stat.pos_zero  = (pos_reg == '0);
        stat.has_child = lc_wide < cnt_wide;
        stat.up_gt     = val_reg > rd0_reg;
        stat.dn_ge     = val_reg >= best_val;
    end

    always_comb
    begin
        if (cmd.rd_parent)
            rd0_addr = parent_idx;
        else if (cmd.rd_children)
            rd0_addr = lc_wide[ADDR_W-1:0];
        else
            rd0_addr = last_idx;
    end

    assign we    = cmd.wr_val || cmd.move_parent || cmd.move_child;
    assign wdata = cmd.move_parent ? rd0_reg : (cmd.move_child ? best_val : val_reg);

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[pos_reg] <= wdata;
        rd0_reg <= heap_mem[rd0_addr];
        rd1_reg <= heap_mem[rc_wide[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.start)
        begin
            if (req_type == REQ_PUSH && !stat.full)
                count_reg <= count_reg + COUNT_W'(1);
            else if (req_type == REQ_POP && !stat.empty)
                count_reg <= count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            popped_reg <= '0;
            stat_reg   <= ST_OK;
            if (req_type == REQ_PUSH)
            begin
                val_reg <= value;
                pos_reg <= count_reg[ADDR_W-1:0];
                if (stat.full)
                    stat_reg <= ST_FULL;
            end
            else
            begin
                pos_reg <= '0;
                if (stat.empty)
                    stat_reg <= ST_EMPTY;
                else
                    popped_reg <= top_reg;
            end
        end
        if (cmd.load_last)
            val_reg <= rd0_reg;
        if (cmd.move_parent)
            pos_reg <= parent_idx;
        if (cmd.move_child)
            pos_reg <= best_idx;
        // The root copy follows every write to the first entry.
        if (we && pos_reg == '0)
            top_reg <= wdata;
        if (cmd.capture)
        begin
            res_status_reg <= stat_reg;
            res_popped_reg <= popped_reg;
            res_top_reg    <= stat.empty ? '0 : top_reg;
            res_count_reg  <= count_reg;
        end
    end

    assign status       = res_status_reg;
    assign popped_value = res_popped_reg;
    assign top_value    = res_top_reg;
    assign entry_count  = res_count_reg;
    assign is_empty     = (res_count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && req_type == REQ_POP && !stat.empty)
            |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("pop did not decrement the count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && stat_reg == ST_FULL) |-> stat.full)
        else $error("full status reported below capacity");

endmodule

### hdl/binary_max_heap_queue_top.sv
// Top level of the binary max-heap priority queue.
// Depends on bmhq_pkg, bmhq_if (channels), bmhq_ctrl and bmhq_dp.
//
//  Channel | Role   | Payload                                                   | Handshake
//  --------+--------+-----------------------------------------------------------+------------
//  req     | sink   | req_type, value                                           | valid/ready
//  rsp     | source | status, popped_value, top_value, entry_count, is_empty    | valid/ready
//
// One request transaction gives one response transaction. Requests are handled one at
// a time; the heap memory has one write and two read ports, and each tree level takes
// a read step, then a compare and move step. A push rises level by level toward the
// root; a pop moves the last entry to the root and sinks it toward a leaf, and a pop
// that removes the last entry needs no sift. At 64 entries a push rises at most six
// levels and a pop sinks at most five. A dropped push or an empty pop goes straight
// to the result register.
// Reset clears the entry count and the handshake state; the heap memory needs no
// clearing since only entries below the count are read. A stalled response sits in the
// result register while the next request transaction is already accepted and worked on.
module binary_max_heap_queue_top (
    input logic        clk,
    input logic        rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);
    import bmhq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The state machine owns sequencing and the response valid flag.
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_type  (req.req_type),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The datapath holds the heap, the moving value and the result register.
    bmhq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req.req_type),
        .value        (req.value),
        .status       (rsp.status),
        .popped_value (rsp.popped_value),
        .top_value    (rsp.top_value),
        .entry_count  (rsp.entry_count),
        .is_empty     (rsp.is_empty)
    );

endmodule

### tb/binary_max_heap_queue_top_tb.sv
// Self-checking testbench for the binary max-heap priority queue top level.
// Depends on bmhq_pkg, the bmhq_req_if/bmhq_rsp_if channels and the RTL under hdl/.
// A mirror heap predicts every response transaction; a watchdog bounds the run.
module binary_max_heap_queue_top_tb;
    import bmhq_pkg::*;

    // Run shape. The quiet tail has no idling on either side. The long receiver
    // hold-off starts at HOLD_AT random items.
    localparam int RAND_ITEMS  = 1800;
    localparam int QUIET_ITEMS = 200;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 240;
    // Cycles with no transaction on either channel before the run is declared hung.
    // The worst correct gap is the receiver hold-off plus the handling of one request.
    localparam int STALL_LIMIT = 1500;
    // The drain outlasts the longest request, so a stray response would show.
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 22;

    localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] V_ALT = 32'sh5555_5555;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

    // One response transaction, as the queue reports it.
    typedef struct {
        logic [STATUS_W-1:0]           status;
        logic signed [VALUE_WIDTH-1:0] popped_value;
        logic signed [VALUE_WIDTH-1:0] top_value;
        logic [COUNT_W-1:0]            entry_count;
        logic                          is_empty;
    } heap_result_t;

    // A row of the directed table. When typed is set the expected response is the
    // one written in the row; otherwise the mirror heap supplies it.
    typedef struct {
        logic                          op;
        logic signed [VALUE_WIDTH-1:0] val;
        bit                            typed;
        logic [STATUS_W-1:0]           st;
        logic signed [VALUE_WIDTH-1:0] popped;
        logic signed [VALUE_WIDTH-1:0] top;
        logic [COUNT_W-1:0]            cnt;
        logic                          emp;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bmhq_req_if req_if ();
    bmhq_rsp_if rsp_if ();

    binary_max_heap_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // Mirror of the heap contents and fill level, updated at each accepted request.
    logic signed [VALUE_WIDTH-1:0] mirror_heap [CAPACITY];
    int unsigned                   mirror_count = 0;

    // Expected response transactions, oldest first.
    heap_result_t pending_results [$];

    directed_row_t dir_rows [DIR_ROWS];

    int  fail_count   = 0;
    int  idle_cycles  = 0;
    bit  src_idle_on  = 1'b1;
    bit  snk_idle_on  = 1'b1;
    bit  hold_rsp     = 1'b0;

    // Coverage tallies for the closing summary.
    int n_push       = 0;
    int n_pop        = 0;
    int n_full_drop  = 0;
    int n_empty_pop  = 0;
    int peak_count   = 0;

    // Applies one request to the mirror heap and returns the response it must give.
    // A push sifts up while strictly greater than its parent. A pop moves the last
    // entry to the root and sifts it down toward the larger child, left on a tie,
    // stopping once it is not below that child.
    function automatic heap_result_t heap_apply_request(
        input logic                          op,
        input logic signed [VALUE_WIDTH-1:0] val
    );
        heap_result_t                  r;
        int unsigned                   pos;
        int unsigned                   par;
        int unsigned                   kid;
        logic signed [VALUE_WIDTH-1:0] tmp;
        r.status       = ST_OK;
        r.popped_value = '0;
        if (op == REQ_PUSH)
        begin
            if (mirror_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = mirror_count;
                mirror_heap[pos] = val;
                mirror_count++;
                while (pos > 0)
                begin
                    par = (pos - 1) / 2;
                    if (mirror_heap[pos] <= mirror_heap[par])
                        break;
                    tmp              = mirror_heap[pos];
                    mirror_heap[pos] = mirror_heap[par];
                    mirror_heap[par] = tmp;
                    pos              = par;
                end
            end
        end
        else if (mirror_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.popped_value = mirror_heap[0];
            mirror_count--;
            mirror_heap[0] = mirror_heap[mirror_count];
            pos = 0;
            while (2 * pos + 1 < mirror_count)
            begin
                kid = 2 * pos + 1;
                if (kid + 1 < mirror_count && mirror_heap[kid + 1] > mirror_heap[kid])
                    kid++;
                if (mirror_heap[pos] >= mirror_heap[kid])
                    break;
                tmp              = mirror_heap[pos];
                mirror_heap[pos] = mirror_heap[kid];
                mirror_heap[kid] = tmp;
                pos              = kid;
            end
        end
        r.top_value   = (mirror_count > 0) ? mirror_heap[0] : '0;
        r.entry_count = COUNT_W'(mirror_count);
        r.is_empty    = (mirror_count == 0);
        return r;
    endfunction

    // Random payload: extremes, a narrow band that makes equal keys common, all
    // zeros or all ones, and fully random words so every bit toggles.
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return V_MAX;
            1:       return V_MIN;
            2, 3, 4: return int'($urandom_range(0, 6)) - 3;
            5:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request transaction, with an optional random gap in front, and
    // records the expected response once the queue accepts it.
    task automatic send_request(
        input logic                          op,
        input logic signed [VALUE_WIDTH-1:0] val,
        input bit                            typed,
        input heap_result_t                  typed_result
    );
        heap_result_t predicted;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.value    <= val;
        do @(posedge clk); while (!req_if.ready);

        predicted = heap_apply_request(op, val);
        if (typed)
            pending_results = {pending_results, typed_result};
        else
            pending_results = {pending_results, predicted};

        if (op == REQ_PUSH)
            n_push++;
        else
            n_pop++;
        if (predicted.status == ST_FULL)
            n_full_drop++;
        if (predicted.status == ST_EMPTY)
            n_empty_pop++;
        if (mirror_count > peak_count)
            peak_count = mirror_count;
    endtask

    task automatic compare_field(
        input string                  name,
        input logic [VALUE_WIDTH-1:0] want,
        input logic [VALUE_WIDTH-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Main stimulus: reset, the directed table, then random phases that alternate
    // between filling the heap past full, draining it past empty, and mixed traffic.
    initial
    begin : stimulus
        heap_result_t  typed_res;
        heap_result_t  no_result;
        traffic_mode_t mode;
        int            phase_left;
        logic          op;

        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_PUSH;
        req_if.value    <= '0;

        no_result  = '{ST_OK, '0, '0, '0, 1'b0};
        mode       = MODE_MIX;
        phase_left = 0;

        // Pop before any push, first pushes at zero and both extremes, equal keys,
        // alternating bit patterns, a full drain and a pop past empty.
        dir_rows[0]  = '{REQ_POP,  0,     1'b1, ST_EMPTY, 0,     0,     0, 1'b1};
        dir_rows[1]  = '{REQ_PUSH, 0,     1'b1, ST_OK,    0,     0,     1, 1'b0};
        dir_rows[2]  = '{REQ_PUSH, V_MAX, 1'b1, ST_OK,    0,     V_MAX, 2, 1'b0};
        dir_rows[3]  = '{REQ_PUSH, V_MIN, 1'b1, ST_OK,    0,     V_MAX, 3, 1'b0};
        dir_rows[4]  = '{REQ_PUSH, -1,    1'b0, ST_OK,    0,     0,     0, 1'b0};
        dir_rows[5]  = '{REQ_PUSH, 5,     1'b0, ST_OK,    0,     0,     0, 1'b0};
        dir_rows[6]  = '{REQ_PUSH, 5,     1'b0, ST_OK,    0,     0,     0, 1'b0};
        dir_rows[7]  = '{REQ_POP,  0,     1'b1, ST_OK,    V_MAX, 5,     5, 1'b0};
        dir_rows[8]  = '{REQ_PUSH, 5,     1'b0, ST_OK,    0,     0,     0, 1'b0};
        dir_rows[9]  = '{REQ_PUSH, V_ALT, 1'b0, ST_OK,    0,     0,     0, 1'b0};
        dir_rows[10] = '{REQ_PUSH, ~V_ALT, 1'b0, ST_OK,   0,     0,     0, 1'b0};
        for (int k = 11; k < 19; k++)
            dir_rows[k] = '{REQ_POP, $urandom, 1'b0, ST_OK, 0, 0, 0, 1'b0};
        dir_rows[19] = '{REQ_POP,  -1,    1'b1, ST_EMPTY, 0,     0,     0, 1'b1};
        dir_rows[20] = '{REQ_PUSH, V_MIN, 1'b1, ST_OK,    0,     V_MIN, 1, 1'b0};
        dir_rows[21] = '{REQ_POP,  V_MAX, 1'b1, ST_OK,    V_MIN, 0,     0, 1'b1};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            typed_res.status       = dir_rows[k].st;
            typed_res.popped_value = dir_rows[k].popped;
            typed_res.top_value    = dir_rows[k].top;
            typed_res.entry_count  = dir_rows[k].cnt;
            typed_res.is_empty     = dir_rows[k].emp;
            send_request(dir_rows[k].op, dir_rows[k].val, dir_rows[k].typed, typed_res);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                mode = (mode == MODE_FILL)  ? MODE_DRAIN :
                       (mode == MODE_DRAIN) ? MODE_MIX   : MODE_FILL;
                phase_left  = $urandom_range(80, 160);
                src_idle_on = ($urandom_range(0, 2) != 0);
                snk_idle_on = ($urandom_range(0, 2) != 0);
            end
            phase_left--;
            if (i >= RAND_ITEMS - QUIET_ITEMS)
            begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            // Park the receiver for a long stretch while requests keep coming, so the
            // result register and the request in flight back up into the input.
            if (i == HOLD_AT)
                hold_rsp = 1'b1;

            case (mode)
                MODE_FILL:  op = ($urandom_range(0, 99) < 85) ? REQ_PUSH : REQ_POP;
                MODE_DRAIN: op = ($urandom_range(0, 99) < 85) ? REQ_POP  : REQ_PUSH;
                default:    op = ($urandom_range(0, 1) == 0)  ? REQ_PUSH : REQ_POP;
            endcase
            send_request(op, pick_value(), 1'b0, no_result);
        end
        req_if.valid <= 1'b0;

        // Let every response arrive, then watch a little longer for strays.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pushes (%0d dropped on a full heap) and %0d pops (%0d on empty),",
                 n_push, n_full_drop, n_pop, n_empty_pop);
        $display("peak fill %0d of %0d entries, with receiver hold-off and random idling.",
                 peak_count, CAPACITY);
        if (fail_count == 0)
            $display("[binary_max_heap_queue_top] OK");
        else
            $display("[binary_max_heap_queue_top] ERROR");
        $finish;
    end

    // Receiver: random stall bursts while enabled, one long hold-off on request,
    // otherwise always ready.
    initial
    begin : rsp_drain
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (snk_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Each response transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: response transaction with no request waiting for it", $time);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status",       VALUE_WIDTH'(want.status),
                              VALUE_WIDTH'(rsp_if.status));
                compare_field("popped_value", want.popped_value, rsp_if.popped_value);
                compare_field("top_value",    want.top_value,    rsp_if.top_value);
                compare_field("entry_count",  VALUE_WIDTH'(want.entry_count),
                              VALUE_WIDTH'(rsp_if.entry_count));
                compare_field("is_empty",     VALUE_WIDTH'(want.is_empty),
                              VALUE_WIDTH'(rsp_if.is_empty));
            end
        end
    end

    // Watchdog: a long run of cycles with no transaction on either channel means the
    // queue has hung.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("[binary_max_heap_queue_top] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### sim.f
hdl/bmhq_pkg.sv
hdl/bmhq_if.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_dp.sv
hdl/binary_max_heap_queue_top.sv
tb/binary_max_heap_queue_top_tb.sv
